@@ rtl/kmedians_color_quantizer_macros.svh @@
`ifndef KMEDIANS_COLOR_QUANTIZER_MACROS_SVH
`define KMEDIANS_COLOR_QUANTIZER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define KMCQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked at the clock edge after the antecedent.
`define KMCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kmcq_pkg.sv @@
`timescale 1ns / 1ps
package kmcq_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int CLU_W        = 4;
    localparam int KCNT_W       = 5;
    localparam int HIST_BINS    = 256;
    localparam int BIN_W        = 8;
    localparam int COUNT_BITS   = 21;
    localparam int SUM_W        = COUNT_BITS + BIN_W;
    localparam int HADDR_W      = CLU_W + BIN_W;
    localparam int HIST_DEPTH   = MAX_CLUSTERS * HIST_BINS;
    localparam int DIST_W       = 18;
    localparam int NUM_CHAN     = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ACC  = 2'd1,
        OP_PASS = 2'd2,
        OP_MAP  = 2'd3
    } op_t;

    localparam logic KIND_MAP  = 1'b0;
    localparam logic KIND_PASS = 1'b1;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    // Control from the sequencer to a median tracker.
    typedef struct packed {
        logic             start;
        logic             sum_en;
        logic             scan_en;
        logic [BIN_W-1:0] bin;
    } med_ctl_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage

@@ rtl/kmcq_dist.sv @@
`timescale 1ns / 1ps
module kmcq_dist (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [kmcq_pkg::CLU_W-1:0]    idx,
    input  logic [7:0]                    pix_r,
    input  logic [7:0]                    pix_g,
    input  logic [7:0]                    pix_b,
    input  logic [7:0]                    cen_r,
    input  logic [7:0]                    cen_g,
    input  logic [7:0]                    cen_b,
    output logic                          d_vld,
    output logic [kmcq_pkg::CLU_W-1:0]    d_idx,
    output logic [kmcq_pkg::DIST_W-1:0]   d
);

    logic [7:0]                  dr, dg, db;
    logic [15:0]                 sr, sg, sb;
    logic [kmcq_pkg::DIST_W-1:0] d_next;
    logic                        d_vld_reg;
    logic [kmcq_pkg::CLU_W-1:0]  d_idx_reg;
    logic [kmcq_pkg::DIST_W-1:0] d_reg;

    always_comb begin
        dr = (pix_r > cen_r) ? pix_r - cen_r : cen_r - pix_r;
        dg = (pix_g > cen_g) ? pix_g - cen_g : cen_g - pix_g;
        db = (pix_b > cen_b) ? pix_b - cen_b : cen_b - pix_b;
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        d_next = {2'b00, sr} + {2'b00, sg} + {2'b00, sb};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else begin
            d_vld_reg <= en;
        end
        d_idx_reg <= idx;
        d_reg     <= d_next;
    end

    assign d_vld = d_vld_reg;
    assign d_idx = d_idx_reg;
    assign d     = d_reg;

endmodule

@@ rtl/kmcq_hist.sv @@
`timescale 1ns / 1ps
module kmcq_hist (
    input  logic                                                         aclk,
    input  logic                                                         we,
    input  logic [kmcq_pkg::NUM_CHAN-1:0][kmcq_pkg::HADDR_W-1:0]         addr,
    input  logic [kmcq_pkg::NUM_CHAN-1:0][kmcq_pkg::COUNT_BITS-1:0]      wdata,
    output logic [kmcq_pkg::NUM_CHAN-1:0][kmcq_pkg::COUNT_BITS-1:0]      rdata
);

    // One bin memory per color channel, addressed by cluster and bin.
    for (genvar ch = 0; ch < kmcq_pkg::NUM_CHAN; ch++) begin : g_chan
        logic [kmcq_pkg::COUNT_BITS-1:0] mem [kmcq_pkg::HIST_DEPTH];
        logic [kmcq_pkg::COUNT_BITS-1:0] rd_reg;

        always_ff @(posedge aclk) begin
            rd_reg <= mem[addr[ch]];
            if (we) begin
                mem[addr[ch]] <= wdata[ch];
            end
        end

        assign rdata[ch] = rd_reg;
    end

endmodule

@@ rtl/kmcq_median.sv @@
`timescale 1ns / 1ps
module kmcq_median (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  kmcq_pkg::med_ctl_t                 ctl,
    input  logic [kmcq_pkg::COUNT_BITS-1:0]    data,
    output logic [kmcq_pkg::BIN_W-1:0]         median
);

    logic [kmcq_pkg::SUM_W-1:0] total_reg, cum_reg, cum_next, m;
    logic                       found_reg, need_w_reg, even;
    logic [kmcq_pkg::BIN_W-1:0] v_reg, res_reg;
    logic [kmcq_pkg::BIN_W:0]   pair_sum;

    always_comb begin
        cum_next = cum_reg + {{(kmcq_pkg::SUM_W-kmcq_pkg::COUNT_BITS){1'b0}}, data};
        m        = (total_reg - 1'b1) >> 1;
        even     = ~total_reg[0];
        pair_sum = {1'b0, v_reg} + {1'b0, ctl.bin};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.start) begin
            total_reg  <= '0;
            cum_reg    <= '0;
            found_reg  <= 1'b0;
            need_w_reg <= 1'b0;
            v_reg      <= '0;
            res_reg    <= '0;
        end else if (ctl.sum_en) begin
            total_reg <= total_reg + {{(kmcq_pkg::SUM_W-kmcq_pkg::COUNT_BITS){1'b0}}, data};
        end else if (ctl.scan_en) begin
            cum_reg <= cum_next;
            if (!found_reg && cum_next > m) begin
                found_reg <= 1'b1;
                v_reg     <= ctl.bin;
                // With an even total whose lower median closes its bin: average with the next filled bin.
                if (even && cum_next == m + 1'b1) begin
                    need_w_reg <= 1'b1;
                end else begin
                    res_reg <= ctl.bin;
                end
            end else if (need_w_reg && data != '0) begin
                res_reg    <= pair_sum[kmcq_pkg::BIN_W:1];
                need_w_reg <= 1'b0;
            end
        end
    end

    assign median = need_w_reg ? v_reg : res_reg;

endmodule

@@ rtl/kmedians_color_quantizer.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_*       in         tuser: operation; tdata: red, green, blue, alpha, slot
// m_*       out        tuser: result_kind; tdata: cluster, color, converged; tlast
// cfg_*     in         cluster_count (5 bits)
//
// Load completes in the idle state; accumulate and map run the distance unit, which handles
// one centroid per cycle; accumulate then reads and writes the histograms, map fills the output register.
// End of pass sweeps the histograms of all 16 clusters (sum, then scan), then makes k output transfers.
// After reset all 4096 entries of the histogram memories are cleared; s_tready stays low meanwhile.
// The output register holds a result while the next item is accepted.
module kmedians_color_quantizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // red, green, blue, alpha, slot, zero pad
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // cluster, out_red, out_green, out_blue, out_alpha,
                                   // converged, zero pad
    output logic        m_tuser,   // result_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    typedef enum logic [9:0] {
        ST_CLEAR   = 10'b0000000001,
        ST_IDLE    = 10'b0000000010,
        ST_NEAR    = 10'b0000000100,
        ST_ACC_RD  = 10'b0000001000,
        ST_ACC_WR  = 10'b0000010000,
        ST_MAP_OUT = 10'b0000100000,
        ST_PSUM    = 10'b0001000000,
        ST_PSCAN   = 10'b0010000000,
        ST_PFIN    = 10'b0100000000,
        ST_EMIT    = 10'b1000000000
    } state_t;

    localparam int CW = kmcq_pkg::CLU_W;
    localparam int NC = kmcq_pkg::NUM_CHAN;

    state_t                          state_reg;
    kmcq_pkg::op_t                   op_reg;
    kmcq_pkg::rgba_t                 pix_reg;
    logic [kmcq_pkg::KCNT_W-1:0]     cc_reg, k;
    logic [CW-1:0]                   klast;
    logic [kmcq_pkg::KCNT_W-1:0]     i_reg;
    logic [CW-1:0]                   best_reg;
    logic [kmcq_pkg::DIST_W-1:0]     best_d_reg;
    kmcq_pkg::rgba_t                 cent_reg  [kmcq_pkg::MAX_CLUSTERS];
    kmcq_pkg::rgba_t                 fresh_reg [kmcq_pkg::MAX_CLUSTERS];
    logic [kmcq_pkg::COUNT_BITS-1:0] mcount_reg [kmcq_pkg::MAX_CLUSTERS];
    logic [7:0]                      falpha_reg [kmcq_pkg::MAX_CLUSTERS];
    logic [kmcq_pkg::MAX_CLUSTERS-1:0] ataken_reg;
    logic [kmcq_pkg::BIN_W:0]        cnt_reg;
    logic                            rd_vld_reg;
    logic [kmcq_pkg::BIN_W-1:0]      bin_d_reg;
    logic [kmcq_pkg::HADDR_W-1:0]    clr_reg;
    logic [CW-1:0]                   clu_reg, e_reg, cent_addr;
    logic                            same_reg;

    logic                            m_tvalid_reg, m_tuser_reg, m_tlast_reg, conv_reg;
    logic [CW-1:0]                   m_clu_reg;
    kmcq_pkg::rgba_t                 m_col_reg;

    logic                            s_acc, issue, sweep_done, out_free, sweep_issue;
    logic                            out_load;
    kmcq_pkg::rgba_t                 cent_rd, fr;
    logic                            d_vld;
    logic [CW-1:0]                   d_idx;
    logic [kmcq_pkg::DIST_W-1:0]     d;
    logic                            h_we;
    logic [NC-1:0][kmcq_pkg::HADDR_W-1:0]    h_addr;
    logic [NC-1:0][kmcq_pkg::COUNT_BITS-1:0] h_wdata, h_rdata;
    kmcq_pkg::med_ctl_t              mctl;
    logic [NC-1:0][kmcq_pkg::BIN_W-1:0]      med;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    // The output register takes a new result this cycle.
    assign out_load  = out_free && ((state_reg == ST_MAP_OUT) || (state_reg == ST_EMIT));

    always_comb begin
        if (cc_reg == '0) begin
            k = 5'd1;
        end else if (cc_reg > 5'(kmcq_pkg::MAX_CLUSTERS)) begin
            k = 5'(kmcq_pkg::MAX_CLUSTERS);
        end else begin
            k = cc_reg;
        end
        klast = CW'(k - 1'b1);
    end

    always_comb begin
        case (state_reg)
            ST_NEAR:    cent_addr = i_reg[CW-1:0];
            ST_MAP_OUT: cent_addr = best_reg;
            ST_PFIN:    cent_addr = clu_reg;
            default:    cent_addr = e_reg;
        endcase
        cent_rd = cent_reg[cent_addr];
    end

    assign issue       = (state_reg == ST_NEAR) && (i_reg < k);
    assign sweep_issue = ((state_reg == ST_PSUM) || (state_reg == ST_PSCAN)) && !cnt_reg[8];
    assign sweep_done  = rd_vld_reg && (bin_d_reg == '1);

    kmcq_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (issue),
        .idx     (i_reg[CW-1:0]),
        .pix_r   (pix_reg.red),
        .pix_g   (pix_reg.green),
        .pix_b   (pix_reg.blue),
        .cen_r   (cent_rd.red),
        .cen_g   (cent_rd.green),
        .cen_b   (cent_rd.blue),
        .d_vld   (d_vld),
        .d_idx   (d_idx),
        .d       (d)
    );

    always_comb begin
        h_we = (state_reg == ST_CLEAR) || (state_reg == ST_ACC_WR)
            || ((state_reg == ST_PSCAN) && sweep_issue);
        for (int ch = 0; ch < NC; ch++) begin
            h_wdata[ch] = (state_reg == ST_ACC_WR) ? kmcq_pkg::sat_inc(h_rdata[ch]) : '0;
        end
        case (state_reg)
            ST_CLEAR: begin
                h_addr = {NC{clr_reg}};
            end
            ST_ACC_RD, ST_ACC_WR: begin
                h_addr[0] = {best_reg, pix_reg.red};
                h_addr[1] = {best_reg, pix_reg.green};
                h_addr[2] = {best_reg, pix_reg.blue};
            end
            default: begin
                h_addr = {NC{{clu_reg, cnt_reg[kmcq_pkg::BIN_W-1:0]}}};
            end
        endcase
    end

    kmcq_hist u_hist (
        .aclk  (aclk),
        .we    (h_we),
        .addr  (h_addr),
        .wdata (h_wdata),
        .rdata (h_rdata)
    );

    always_comb begin
        mctl.start   = (s_acc && s_tuser == kmcq_pkg::OP_PASS) || (state_reg == ST_PFIN);
        mctl.sum_en  = (state_reg == ST_PSUM) && rd_vld_reg;
        mctl.scan_en = (state_reg == ST_PSCAN) && rd_vld_reg;
        mctl.bin     = bin_d_reg;
    end

    for (genvar ch = 0; ch < NC; ch++) begin : g_med
        kmcq_median u_med (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (mctl),
            .data    (h_rdata[ch]),
            .median  (med[ch])
        );
    end

    always_comb begin
        if (mcount_reg[clu_reg] == '0) begin
            fr = '0;
        end else begin
            fr.red   = med[0];
            fr.green = med[1];
            fr.blue  = med[2];
            fr.alpha = falpha_reg[clu_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cc_reg       <= 5'(kmcq_pkg::MAX_CLUSTERS);
            clr_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            ataken_reg   <= '0;
            for (int j = 0; j < kmcq_pkg::MAX_CLUSTERS; j++) begin
                cent_reg[j]   <= '0;
                mcount_reg[j] <= '0;
                falpha_reg[j] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                cc_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            rd_vld_reg <= sweep_issue;
            bin_d_reg  <= cnt_reg[kmcq_pkg::BIN_W-1:0];
            if (sweep_issue) begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        op_reg  <= kmcq_pkg::op_t'(s_tuser);
                        pix_reg <= s_tdata[31:0];
                        i_reg   <= '0;
                        case (kmcq_pkg::op_t'(s_tuser))
                            kmcq_pkg::OP_LOAD: begin
                                cent_reg[s_tdata[35:32]] <= s_tdata[31:0];
                            end
                            kmcq_pkg::OP_PASS: begin
                                clu_reg   <= '0;
                                cnt_reg   <= '0;
                                same_reg  <= 1'b1;
                                state_reg <= ST_PSUM;
                            end
                            default: begin
                                state_reg <= ST_NEAR;
                            end
                        endcase
                    end
                end
                ST_NEAR: begin
                    if (issue) begin
                        i_reg <= i_reg + 1'b1;
                    end
                    if (d_vld) begin
                        if (d_idx == '0 || d < best_d_reg) begin
                            best_d_reg <= d;
                            best_reg   <= d_idx;
                        end
                        if (d_idx == klast) begin
                            state_reg <= (op_reg == kmcq_pkg::OP_MAP) ? ST_MAP_OUT : ST_ACC_RD;
                        end
                    end
                end
                ST_ACC_RD: begin
                    state_reg <= ST_ACC_WR;
                end
                ST_ACC_WR: begin
                    mcount_reg[best_reg] <= kmcq_pkg::sat_inc(mcount_reg[best_reg]);
                    if (!ataken_reg[best_reg]) begin
                        falpha_reg[best_reg] <= pix_reg.alpha;
                        ataken_reg[best_reg] <= 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_MAP_OUT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= kmcq_pkg::KIND_MAP;
                        m_clu_reg    <= best_reg;
                        m_col_reg    <= cent_rd;
                        conv_reg     <= 1'b0;
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_PSUM: begin
                    if (sweep_done) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_PSCAN;
                    end
                end
                ST_PSCAN: begin
                    if (sweep_done) begin
                        state_reg <= ST_PFIN;
                    end
                end
                ST_PFIN: begin
                    fresh_reg[clu_reg] <= fr;
                    if ({1'b0, clu_reg} < k && fr != cent_rd) begin
                        same_reg <= 1'b0;
                    end
                    // Every cluster is swept so that all bins are cleared, even above k.
                    if (clu_reg == '1) begin
                        e_reg      <= '0;
                        ataken_reg <= '0;
                        for (int j = 0; j < kmcq_pkg::MAX_CLUSTERS; j++) begin
                            mcount_reg[j] <= '0;
                            falpha_reg[j] <= '0;
                        end
                        state_reg <= ST_EMIT;
                    end else begin
                        clu_reg   <= clu_reg + 1'b1;
                        cnt_reg   <= '0;
                        state_reg <= ST_PSUM;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg    <= 1'b1;
                        m_tuser_reg     <= kmcq_pkg::KIND_PASS;
                        m_clu_reg       <= e_reg;
                        m_col_reg       <= fresh_reg[e_reg];
                        conv_reg        <= same_reg;
                        m_tlast_reg     <= (e_reg == klast);
                        cent_reg[e_reg] <= fresh_reg[e_reg];
                        e_reg           <= e_reg + 1'b1;
                        if (e_reg == klast) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {3'b000, conv_reg, m_col_reg, m_clu_reg};

endmodule

@@ rtl/kmcq_checker.sv @@
`timescale 1ns / 1ps
`include "kmedians_color_quantizer_macros.svh"
module kmcq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    `KMCQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `KMCQ_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "stalled result changed")
    `KMCQ_ASSERT_IMP(a_map_single, m_tvalid && m_tuser == kmcq_pkg::KIND_MAP, m_tlast && !m_tdata[36], "mapped result must be last and not converged")
    `KMCQ_ASSERT_NEXT(a_busy_after, s_tvalid && s_tready && (s_tuser == kmcq_pkg::OP_ACC || s_tuser == kmcq_pkg::OP_MAP || s_tuser == kmcq_pkg::OP_PASS), !s_tready, "input taken during work")

endmodule

bind kmedians_color_quantizer kmcq_checker u_kmcq_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [3:0] slot;
    } pixel_cmd_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] cluster;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       converged;
        logic       last;
    } centroid_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    kmedians_color_quantizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    pixel_cmd_t    cmd_queue[$];
    centroid_res_t centroid_exp[$];
    int            mismatches = 0;
    int            items_pushed = 0;
    bit            calm = 1'b0;
    bit            s_fire = 1'b0;

    // Shadow state of the block.
    logic [7:0] cent[kmcq_pkg::MAX_CLUSTERS][4];
    logic [kmcq_pkg::COUNT_BITS-1:0]
        hist[kmcq_pkg::MAX_CLUSTERS][kmcq_pkg::NUM_CHAN][kmcq_pkg::HIST_BINS];
    logic [kmcq_pkg::COUNT_BITS-1:0] members[kmcq_pkg::MAX_CLUSTERS];
    logic [7:0] alpha0[kmcq_pkg::MAX_CLUSTERS];
    bit         alpha_set[kmcq_pkg::MAX_CLUSTERS];
    logic [4:0] k_reg = 5'd16;

    function automatic int k_eff();
        if (k_reg == 0) return 1;
        if (k_reg > kmcq_pkg::MAX_CLUSTERS) return kmcq_pkg::MAX_CLUSTERS;
        return k_reg;
    endfunction

    function automatic int nearest_cluster(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int best, best_d, d, dr, dg, db;
        best = 0;
        best_d = 0;
        for (int i = 0; i < k_eff(); i++) begin
            dr = int'(r) - int'(cent[i][0]);
            dg = int'(g) - int'(cent[i][1]);
            db = int'(b) - int'(cent[i][2]);
            d = dr * dr + dg * dg + db * db;
            if (i == 0 || d < best_d) begin
                best_d = d;
                best = i;
            end
        end
        return best;
    endfunction

    function automatic logic [7:0] channel_median(int c, int ch);
        longint total, m, cum;
        total = 0;
        cum = 0;
        for (int v = 0; v < kmcq_pkg::HIST_BINS; v++) total += hist[c][ch][v];
        if (total == 0) return 8'd0;
        m = (total - 1) / 2;
        for (int v = 0; v < kmcq_pkg::HIST_BINS; v++) begin
            cum += hist[c][ch][v];
            if (cum > m) begin
                // Even total whose lower median closes its bin: average with the next bin.
                if (total % 2 == 0 && cum == m + 1) begin
                    for (int w = v + 1; w < kmcq_pkg::HIST_BINS; w++)
                        if (hist[c][ch][w] != 0) return 8'((v + w) / 2);
                end
                return 8'(v);
            end
        end
        return 8'd0;
    endfunction

    function automatic void clear_pass_state();
        for (int c = 0; c < kmcq_pkg::MAX_CLUSTERS; c++) begin
            for (int ch = 0; ch < kmcq_pkg::NUM_CHAN; ch++)
                for (int v = 0; v < kmcq_pkg::HIST_BINS; v++) hist[c][ch][v] = '0;
            members[c] = '0;
            alpha0[c] = '0;
            alpha_set[c] = 1'b0;
        end
    endfunction

    function automatic logic [kmcq_pkg::COUNT_BITS-1:0] sat_count(
        logic [kmcq_pkg::COUNT_BITS-1:0] v);
        return (v == kmcq_pkg::COUNT_MAX) ? kmcq_pkg::COUNT_MAX : v + 1'b1;
    endfunction

    function automatic void predict_cmd(pixel_cmd_t p);
        int c, k;
        bit same;
        logic [7:0] fresh[kmcq_pkg::MAX_CLUSTERS][4];
        centroid_res_t res;
        case (kmcq_pkg::op_t'(p.op))
            kmcq_pkg::OP_LOAD: begin
                cent[p.slot][0] = p.red;
                cent[p.slot][1] = p.green;
                cent[p.slot][2] = p.blue;
                cent[p.slot][3] = p.alpha;
            end
            kmcq_pkg::OP_ACC: begin
                c = nearest_cluster(p.red, p.green, p.blue);
                hist[c][0][p.red]   = sat_count(hist[c][0][p.red]);
                hist[c][1][p.green] = sat_count(hist[c][1][p.green]);
                hist[c][2][p.blue]  = sat_count(hist[c][2][p.blue]);
                members[c] = sat_count(members[c]);
                if (!alpha_set[c]) begin
                    alpha0[c] = p.alpha;
                    alpha_set[c] = 1'b1;
                end
            end
            kmcq_pkg::OP_MAP: begin
                c = nearest_cluster(p.red, p.green, p.blue);
                res = '{kmcq_pkg::KIND_MAP, 4'(c), cent[c][0], cent[c][1], cent[c][2],
                        cent[c][3], 1'b0, 1'b1};
                centroid_exp = {centroid_exp, res};
            end
            default: begin
                k = k_eff();
                same = 1'b1;
                for (int i = 0; i < k; i++) begin
                    if (members[i] == 0) begin
                        for (int j = 0; j < 4; j++) fresh[i][j] = 8'd0;
                    end else begin
                        for (int ch = 0; ch < kmcq_pkg::NUM_CHAN; ch++)
                            fresh[i][ch] = channel_median(i, ch);
                        fresh[i][3] = alpha0[i];
                    end
                    for (int j = 0; j < 4; j++) if (fresh[i][j] != cent[i][j]) same = 1'b0;
                end
                for (int i = 0; i < k; i++) begin
                    res = '{kmcq_pkg::KIND_PASS, 4'(i), fresh[i][0], fresh[i][1], fresh[i][2],
                            fresh[i][3], same, (i == k - 1)};
                    centroid_exp = {centroid_exp, res};
                    for (int j = 0; j < 4; j++) cent[i][j] = fresh[i][j];
                end
                clear_pass_state();
            end
        endcase
    endfunction

    // Driver: presents queued commands, changes inputs on the falling edge.
    always @(negedge aclk) begin
        if (!s_tvalid || s_fire) begin
            if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
                pixel_cmd_t p;
                p = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= p.op;
                s_tdata  <= {4'd0, p.slot, p.alpha, p.blue, p.green, p.red};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= calm || ($urandom_range(99) >= 35);
    end

    // Monitor: predicts on every accepted command and checks every result transfer.
    always @(posedge aclk) begin
        centroid_res_t got, want;
        s_fire <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            predict_cmd('{s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16],
                          s_tdata[31:24], s_tdata[35:32]});
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[3:0], m_tdata[11:4], m_tdata[19:12], m_tdata[27:20],
                    m_tdata[35:28], m_tdata[36], m_tlast};
            if (centroid_exp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer: %p", got);
            end else begin
                want = centroid_exp.pop_front();
                if (got.kind !== want.kind || got.cluster !== want.cluster ||
                    got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.alpha !== want.alpha ||
                    got.converged !== want.converged || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    task automatic push_cmd(kmcq_pkg::op_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] a, logic [3:0] slot);
        pixel_cmd_t p;
        p = '{op, r, g, b, a, slot};
        cmd_queue = {cmd_queue, p};
        items_pushed++;
    endtask

    // Holds the sender until the block has drained, then lets it settle.
    task automatic wait_idle();
        while (cmd_queue.size() > 0 || s_tvalid || centroid_exp.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_k(logic [4:0] v);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do @(posedge aclk); while (!cfg_ready);
        k_reg = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] jitter(logic [7:0] base);
        int v;
        v = int'(base) + $urandom_range(40) - 20;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    initial begin
        logic [7:0] seeds[kmcq_pkg::MAX_CLUSTERS][3];
        pixel_cmd_t pass_pixels[$];
        logic [4:0] kv;
        int n, c;
        for (int i = 0; i < kmcq_pkg::MAX_CLUSTERS; i++)
            for (int j = 0; j < 4; j++) cent[i][j] = 8'd0;
        clear_pass_state();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: map against reset centroids, an empty pass, extremes, tie and even totals.
        push_cmd(kmcq_pkg::OP_MAP, 8'd255, 8'd255, 8'd255, 8'd255, 4'd0);
        push_cmd(kmcq_pkg::OP_PASS, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0);
        wait_idle();
        write_k(5'd0);
        push_cmd(kmcq_pkg::OP_LOAD, 8'd255, 8'd0, 8'd255, 8'd170, 4'd15);
        push_cmd(kmcq_pkg::OP_LOAD, 8'd10, 8'd20, 8'd30, 8'd40, 4'd0);
        push_cmd(kmcq_pkg::OP_ACC, 8'd0, 8'd0, 8'd0, 8'd7, 4'd15);
        push_cmd(kmcq_pkg::OP_ACC, 8'd255, 8'd255, 8'd255, 8'd9, 4'd0);
        push_cmd(kmcq_pkg::OP_MAP, 8'd255, 8'd0, 8'd255, 8'd0, 4'd0);
        push_cmd(kmcq_pkg::OP_PASS, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0);
        wait_idle();
        write_k(5'd2);
        // Two centroids equidistant from the pixel: the lower index takes it.
        push_cmd(kmcq_pkg::OP_LOAD, 8'd100, 8'd100, 8'd100, 8'd1, 4'd0);
        push_cmd(kmcq_pkg::OP_LOAD, 8'd120, 8'd100, 8'd100, 8'd2, 4'd1);
        push_cmd(kmcq_pkg::OP_ACC, 8'd110, 8'd100, 8'd100, 8'd3, 4'd0);
        push_cmd(kmcq_pkg::OP_ACC, 8'd116, 8'd90, 8'd101, 8'd4, 4'd0);
        push_cmd(kmcq_pkg::OP_ACC, 8'd130, 8'd95, 8'd102, 8'd5, 4'd0);
        push_cmd(kmcq_pkg::OP_ACC, 8'd130, 8'd95, 8'd102, 8'd6, 4'd0);
        push_cmd(kmcq_pkg::OP_ACC, 8'd140, 8'd110, 8'd104, 8'd7, 4'd0);
        push_cmd(kmcq_pkg::OP_MAP, 8'd110, 8'd100, 8'd100, 8'd0, 4'd0);
        push_cmd(kmcq_pkg::OP_PASS, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0);
        push_cmd(kmcq_pkg::OP_PASS, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0);
        wait_idle();
        write_k(5'd31);
        push_cmd(kmcq_pkg::OP_MAP, 8'd3, 8'd3, 8'd3, 8'd3, 4'd0);
        wait_idle();

        // Random passes: load seeds, accumulate pixels around them, map some random pixels, end the pass,
        // and sometimes rerun the same pixels so the centroids can settle.
        while (items_pushed < 410) begin
            calm = (items_pushed > 170 && items_pushed < 260);
            kv = 5'($urandom_range(31));
            write_k(kv);
            for (int i = 0; i < kmcq_pkg::MAX_CLUSTERS; i++) begin
                for (int j = 0; j < 3; j++) seeds[i][j] = 8'($urandom_range(255));
                if ($urandom_range(99) < 70)
                    push_cmd(kmcq_pkg::OP_LOAD, seeds[i][0], seeds[i][1], seeds[i][2],
                             8'($urandom_range(255)), 4'(i));
            end
            pass_pixels.delete();
            n = $urandom_range(4, 20);
            for (int i = 0; i < n; i++) begin
                pixel_cmd_t p;
                c = $urandom_range(kmcq_pkg::MAX_CLUSTERS - 1);
                p.op = kmcq_pkg::OP_ACC;
                if ($urandom_range(99) < 80) begin
                    p.red = jitter(seeds[c][0]);
                    p.green = jitter(seeds[c][1]);
                    p.blue = jitter(seeds[c][2]);
                end else begin
                    p.red = 8'($urandom_range(255));
                    p.green = 8'($urandom_range(255));
                    p.blue = 8'($urandom_range(255));
                end
                p.alpha = 8'($urandom_range(255));
                p.slot = 4'($urandom_range(15));
                pass_pixels = {pass_pixels, p};
                if ($urandom_range(3) == 0) pass_pixels = {pass_pixels, p};
            end
            for (int rep = 0; rep < (($urandom_range(2) == 0) ? 3 : 1); rep++) begin
                foreach (pass_pixels[i]) begin
                    cmd_queue = {cmd_queue, pass_pixels[i]};
                    items_pushed++;
                    if ($urandom_range(9) == 0)
                        push_cmd(kmcq_pkg::OP_MAP, 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 4'($urandom_range(15)));
                end
                push_cmd(kmcq_pkg::OP_PASS, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         4'($urandom_range(15)));
            end
            wait_idle();
        end
        calm = 1'b0;
        wait_idle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
